// File: rtl/gradient_pixel_generator_core_defines.svh
// Assertion macros for the gradient pixel generator.
// Used by the top level; the clock and reset names in scope must be clk and rst.
`ifndef GRADIENT_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define GRADIENT_PIXEL_GENERATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define GPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gradient pixel generator assertion failed");
// Checked at every edge, reset included.
`define GPG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gradient pixel generator reset check failed");
`else
`define GPG_ASSERT(lbl, prop)
`define GPG_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/gpg_pkg.sv
// Shared constants, register indexes and pipeline record types of the gradient generator.
// No dependencies.
package gpg_pkg;

  // Dither matrix side; must be a power of two.
  localparam int DITHER_DIM  = 4;
  localparam int COORD_BITS  = 16;
  localparam int DITHER_BITS = (DITHER_DIM > 1) ? $clog2(DITHER_DIM) : 1;
  localparam int PIX_BITS    = 15;
  localparam int FRAC_BITS   = 16;

  // Signed width of coordinate differences; product and divider lane widths derive from it.
  localparam int SW   = ((COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS) + 2;
  localparam int PW   = 2 * SW;
  localparam int DIVW = PW + 2;
  localparam int ROOT_W = 2 * FRAC_BITS;

  localparam logic [FRAC_BITS:0] F_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // Configuration register indexes.
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] REG_MODE        = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_START_X     = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_START_Y     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_END_X       = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_END_Y       = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_COLOR_START = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_COLOR_END   = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_DITHER      = IDX_W'(7);

  // Mode bits.
  localparam int MODE_RADIAL = 0;
  localparam int MODE_DITHER = 1;

  // Which fixed color an early-decided pixel takes.
  typedef enum logic [1:0] {
    FIX_START_RAW,
    FIX_END_RAW,
    FIX_END_ADJ
  } fsel_t;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [COORD_BITS-1:0]        sx;
    logic [COORD_BITS-1:0]        sy;
    logic [COORD_BITS-1:0]        ex;
    logic [COORD_BITS-1:0]        ey;
    logic [31:0]                  c0;
    logic [31:0]                  c1;
    logic [63:0]                  dtab;
    logic [3:0]                   dmax;
  } cfg_t;

  typedef struct packed {
    logic                   fixed;
    fsel_t                  fsel;
    logic                   lo;
    logic                   hi;
    logic [DITHER_BITS-1:0] pxm;
    logic [DITHER_BITS-1:0] pym;
  } side_t;

  typedef struct packed {
    logic [DIVW-1:0]      rx;
    logic [DIVW-1:0]      ddx;
    logic [DIVW-1:0]      ry;
    logic [DIVW-1:0]      ddy;
    logic [FRAC_BITS-1:0] qx;
    logic [FRAC_BITS-1:0] qy;
    side_t                side;
  } div_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  v;
    logic [ROOT_W:0]    res;
    logic [FRAC_BITS:0] f;
    side_t              side;
  } root_t;

endpackage

// File: rtl/gradient_pixel_generator_core.sv
// Gradient pixel generator, top level.
// Channels: pixel positions enter on in_valid/in_ready (pixel_x, pixel_y); one RGBA
// color per position leaves on out_valid/out_ready (pixel_color). Registers are
// written over cfg_valid/cfg_ready (cfg_index, cfg_data); cfg_ready is always high.
// Writes must be made while no transaction is in flight; the block does not enforce this.
// From input transaction to result the pipeline has three front stages,
// sixteen divider stages (one quotient bit each), two squaring stages, sixteen
// square root stages (one root bit each) and two color stages.
// Throughput is one pixel per clock while the output is not stalled; every stage is a plain register stage.
// When the receiver holds out_ready low with a result waiting, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated.
// Reset clears the configuration registers to zero and empties the pipeline.
// Depends on gpg_pkg, gpg_front, gpg_div_step, gpg_prep, gpg_sqrt_step, gpg_color.
`include "gradient_pixel_generator_core_defines.svh"
module gradient_pixel_generator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gpg_pkg::IDX_W-1:0]     cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gpg_pkg::PIX_BITS-1:0]  pixel_x,
  input  logic [gpg_pkg::PIX_BITS-1:0]  pixel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   pixel_color
);

  localparam int NSTEP = gpg_pkg::FRAC_BITS;

  gpg_pkg::cfg_t   cfg;
  logic            en;
  logic [3:0]      row_max      [gpg_pkg::DITHER_DIM];
  logic [3:0]      row_max_next [gpg_pkg::DITHER_DIM];
  logic [3:0]      dmax_next;

  gpg_pkg::div_t   div_d  [NSTEP+1];
  logic [NSTEP:0]  div_v;
  gpg_pkg::root_t  root_d [NSTEP+1];
  logic [NSTEP:0]  sqrt_v;

  // The pipeline moves unless a finished result is waiting.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Largest threshold of the used matrix area, row maxima then overall maximum.
  always_comb begin
    for (int r = 0; r < gpg_pkg::DITHER_DIM; r++) begin
      row_max_next[r] = 4'h0;
      for (int c = 0; c < gpg_pkg::DITHER_DIM; c++) begin
        if (cfg.dtab[4*(4*r+c) +: 4] > row_max_next[r]) begin
          row_max_next[r] = cfg.dtab[4*(4*r+c) +: 4];
        end
      end
    end
    dmax_next = 4'h0;
    for (int r = 0; r < gpg_pkg::DITHER_DIM; r++) begin
      if (row_max[r] > dmax_next) begin
        dmax_next = row_max[r];
      end
    end
  end

  // Configuration registers and the dither maximum derived from them.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= '0;
      cfg.sx   <= '0;
      cfg.sy   <= '0;
      cfg.ex   <= '0;
      cfg.ey   <= '0;
      cfg.c0   <= '0;
      cfg.c1   <= '0;
      cfg.dtab <= '0;
      cfg.dmax <= '0;
      for (int r = 0; r < gpg_pkg::DITHER_DIM; r++) begin
        row_max[r] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gpg_pkg::REG_MODE:        cfg.mode <= cfg_data[1:0];
          gpg_pkg::REG_START_X:     cfg.sx   <= cfg_data[gpg_pkg::COORD_BITS-1:0];
          gpg_pkg::REG_START_Y:     cfg.sy   <= cfg_data[gpg_pkg::COORD_BITS-1:0];
          gpg_pkg::REG_END_X:       cfg.ex   <= cfg_data[gpg_pkg::COORD_BITS-1:0];
          gpg_pkg::REG_END_Y:       cfg.ey   <= cfg_data[gpg_pkg::COORD_BITS-1:0];
          gpg_pkg::REG_COLOR_START: cfg.c0   <= cfg_data[31:0];
          gpg_pkg::REG_COLOR_END:   cfg.c1   <= cfg_data[31:0];
          gpg_pkg::REG_DITHER:      cfg.dtab <= cfg_data;
          default: ;
        endcase
      end
      row_max  <= row_max_next;
      cfg.dmax <= dmax_next;
    end
  end

  // Front end.
  gpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_valid (div_v[0]),
    .dout      (div_d[0])
  );

  // Divider chain, one quotient bit per stage.
  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    gpg_div_step u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_v[i]),
      .din       (div_d[i]),
      .out_valid (div_v[i+1]),
      .dout      (div_d[i+1])
    );
  end

  gpg_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (div_v[NSTEP]),
    .din       (div_d[NSTEP]),
    .out_valid (sqrt_v[0]),
    .dout      (root_d[0])
  );

  // Square root chain, most significant root bit first.
  for (genvar i = 0; i < NSTEP; i++) begin : g_sqrt
    gpg_sqrt_step u_sqrt (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .step      (4'(NSTEP - 1 - i)),
      .in_valid  (sqrt_v[i]),
      .din       (root_d[i]),
      .out_valid (sqrt_v[i+1]),
      .dout      (root_d[i+1])
    );
  end

  gpg_color u_color (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .in_valid    (sqrt_v[NSTEP]),
    .din         (root_d[NSTEP]),
    .out_valid   (out_valid),
    .pixel_color (pixel_color)
  );

  // Reset empties the output stage.
  `GPG_ASSERT_RST(a_reset_empty, $past(rst) |-> !out_valid)
  // A stall freezes every stage's valid bit.
  `GPG_ASSERT(a_stall_freeze, !en |=> $stable(div_v) && $stable(sqrt_v))
  // Valid bits shift one divider stage per enabled cycle.
  `GPG_ASSERT(a_div_shift, en |=> div_v[NSTEP:1] == $past(div_v[NSTEP-1:0]))
  // Valid bits shift one root stage per enabled cycle.
  `GPG_ASSERT(a_sqrt_shift, en |=> sqrt_v[NSTEP:1] == $past(sqrt_v[NSTEP-1:0]))

endmodule

// File: rtl/gpg_front.sv
// Front end: three stages that form differences, products and the divider operands.
// Depends on gpg_pkg.
module gpg_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  gpg_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  input  logic [gpg_pkg::PIX_BITS-1:0]     pixel_x,
  input  logic [gpg_pkg::PIX_BITS-1:0]     pixel_y,
  output logic                             out_valid,
  output gpg_pkg::div_t                    dout
);

  logic signed [gpg_pkg::SW-1:0] px_e, py_e, sx_e, sy_e, ex_e, ey_e;

  // Stage 1 registers.
  logic                                v1;
  logic signed [gpg_pkg::SW-1:0]       dx, dy, wx, wy, aa, bb;
  logic [gpg_pkg::DITHER_BITS-1:0]     pxm1, pym1;
  logic                                deg_lin1, deg_rad1;

  // Stage 2 registers.
  logic                                v2;
  logic signed [gpg_pkg::PW-1:0]       pdx, pdy, pwx, pwy;
  logic [gpg_pkg::SW-1:0]              ma, mb, mw, mh;
  logic [gpg_pkg::DITHER_BITS-1:0]     pxm2, pym2;
  logic                                deg_lin2, deg_rad2;

  // Stage 3 combinational values.
  logic signed [gpg_pkg::PW:0]         dot;
  logic [gpg_pkg::PW:0]                den;
  logic                                lo, hi, outside, radial;
  gpg_pkg::side_t                      side;

  assign px_e = signed'({{(gpg_pkg::SW - gpg_pkg::PIX_BITS){1'b0}}, pixel_x});
  assign py_e = signed'({{(gpg_pkg::SW - gpg_pkg::PIX_BITS){1'b0}}, pixel_y});
  assign sx_e = gpg_pkg::SW'($signed(cfg.sx));
  assign sy_e = gpg_pkg::SW'($signed(cfg.sy));
  assign ex_e = gpg_pkg::SW'($signed(cfg.ex));
  assign ey_e = gpg_pkg::SW'($signed(cfg.ey));
  assign radial = cfg.mode[gpg_pkg::MODE_RADIAL];

  // Stage 1: differences and degenerate-point checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      dx       <= px_e - sx_e;
      dy       <= py_e - sy_e;
      wx       <= ex_e - sx_e;
      wy       <= ey_e - sy_e;
      aa       <= (px_e <<< 1) - sx_e - ex_e;
      bb       <= (py_e <<< 1) - sy_e - ey_e;
      pxm1     <= pixel_x[gpg_pkg::DITHER_BITS-1:0];
      pym1     <= pixel_y[gpg_pkg::DITHER_BITS-1:0];
      deg_lin1 <= (cfg.sx == cfg.ex) && (cfg.sy == cfg.ey);
      deg_rad1 <= (cfg.sx == cfg.ex) || (cfg.sy == cfg.ey);
    end
  end

  // Stage 2: products for the projection and magnitudes for the ellipse.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      pdx      <= dx * wx;
      pdy      <= dy * wy;
      pwx      <= wx * wx;
      pwy      <= wy * wy;
      ma       <= aa[gpg_pkg::SW-1] ? $unsigned(-aa) : $unsigned(aa);
      mb       <= bb[gpg_pkg::SW-1] ? $unsigned(-bb) : $unsigned(bb);
      mw       <= wx[gpg_pkg::SW-1] ? $unsigned(-wx) : $unsigned(wx);
      mh       <= wy[gpg_pkg::SW-1] ? $unsigned(-wy) : $unsigned(wy);
      pxm2     <= pxm1;
      pym2     <= pym1;
      deg_lin2 <= deg_lin1;
      deg_rad2 <= deg_rad1;
    end
  end

  // Stage 3: dot product, clamp decisions and fixed-color cases.
  always_comb begin
    dot     = (gpg_pkg::PW + 1)'(pdx) + (gpg_pkg::PW + 1)'(pdy);
    den     = (gpg_pkg::PW + 1)'($unsigned(pwx)) + (gpg_pkg::PW + 1)'($unsigned(pwy));
    lo      = dot[gpg_pkg::PW];
    hi      = !lo && ($unsigned(dot) >= den);
    outside = (ma >= mw) || (mb >= mh);
    side.fixed = 1'b0;
    side.fsel  = gpg_pkg::FIX_END_ADJ;
    side.lo    = lo;
    side.hi    = hi;
    side.pxm   = pxm2;
    side.pym   = pym2;
    if (!radial && deg_lin2) begin
      side.fixed = 1'b1;
      side.fsel  = gpg_pkg::FIX_START_RAW;
    end else if (radial && deg_rad2) begin
      side.fixed = 1'b1;
      side.fsel  = gpg_pkg::FIX_END_RAW;
    end else if (radial && outside) begin
      side.fixed = 1'b1;
      side.fsel  = gpg_pkg::FIX_END_ADJ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      if (radial) begin
        dout.rx  <= gpg_pkg::DIVW'(ma);
        dout.ddx <= gpg_pkg::DIVW'(mw);
      end else begin
        dout.rx  <= gpg_pkg::DIVW'($unsigned(dot));
        dout.ddx <= gpg_pkg::DIVW'(den);
      end
      dout.ry   <= gpg_pkg::DIVW'(mb);
      dout.ddy  <= gpg_pkg::DIVW'(mh);
      dout.qx   <= '0;
      dout.qy   <= '0;
      dout.side <= side;
    end
  end

endmodule

// File: rtl/gpg_div_step.sv
// One restoring-division stage: one quotient bit on each of two lanes.
// Depends on gpg_pkg.
module gpg_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  gpg_pkg::div_t din,
  output logic          out_valid,
  output gpg_pkg::div_t dout
);

  logic [gpg_pkg::DIVW:0] tx, ty;
  logic                   gx, gy;

  // Shift the partial remainder and try to subtract the divisor.
  always_comb begin
    tx = {din.rx, 1'b0};
    ty = {din.ry, 1'b0};
    gx = tx >= {1'b0, din.ddx};
    gy = ty >= {1'b0, din.ddy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      dout     <= din;
      dout.rx  <= gx ? gpg_pkg::DIVW'(tx - {1'b0, din.ddx}) : gpg_pkg::DIVW'(tx);
      dout.ry  <= gy ? gpg_pkg::DIVW'(ty - {1'b0, din.ddy}) : gpg_pkg::DIVW'(ty);
      dout.qx  <= {din.qx[gpg_pkg::FRAC_BITS-2:0], gx};
      dout.qy  <= {din.qy[gpg_pkg::FRAC_BITS-2:0], gy};
    end
  end

endmodule

// File: rtl/gpg_prep.sv
// Two stages between divider and square root: squares, then their sum and the
// linear factor. Depends on gpg_pkg.
module gpg_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  gpg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  gpg_pkg::div_t  din,
  output logic           out_valid,
  output gpg_pkg::root_t dout
);

  logic                           v1;
  logic [gpg_pkg::ROOT_W-1:0]     sqx, sqy;
  logic [gpg_pkg::FRAC_BITS-1:0]  qx1;
  gpg_pkg::side_t                 side1, side2;
  logic [gpg_pkg::ROOT_W:0]       sum;
  logic [gpg_pkg::FRAC_BITS:0]    flin;

  // Stage 1: square both normalized distances.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      sqx   <= din.qx * din.qx;
      sqy   <= din.qy * din.qy;
      qx1   <= din.qx;
      side1 <= din.side;
    end
  end

  // Stage 2: radius squared, overflow marks the pixel outside in radial mode; linear factor clamped.
  always_comb begin
    sum   = (gpg_pkg::ROOT_W + 1)'(sqx) + (gpg_pkg::ROOT_W + 1)'(sqy);
    side2 = side1;
    if (cfg.mode[gpg_pkg::MODE_RADIAL] && !side1.fixed && sum[gpg_pkg::ROOT_W]) begin
      side2.fixed = 1'b1;
      side2.fsel  = gpg_pkg::FIX_END_ADJ;
    end
    if (side1.lo) begin
      flin = '0;
    end else if (side1.hi) begin
      flin = gpg_pkg::F_ONE;
    end else begin
      flin = {1'b0, qx1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      dout.v    <= sum[gpg_pkg::ROOT_W-1:0];
      dout.res  <= '0;
      dout.f    <= flin;
      dout.side <= side2;
    end
  end

endmodule

// File: rtl/gpg_sqrt_step.sv
// One digit-by-digit square root stage; the step input selects the bit pair.
// Depends on gpg_pkg.
module gpg_sqrt_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [3:0]     step,
  input  logic           in_valid,
  input  gpg_pkg::root_t din,
  output logic           out_valid,
  output gpg_pkg::root_t dout
);

  logic [gpg_pkg::ROOT_W:0] bitv, trial;
  logic                     take;

  // Try to subtract the current root estimate plus the bit.
  always_comb begin
    bitv  = (gpg_pkg::ROOT_W + 1)'(1) << {step, 1'b0};
    trial = din.res + bitv;
    take  = {1'b0, din.v} >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      dout <= din;
      if (take) begin
        dout.v   <= gpg_pkg::ROOT_W'({1'b0, din.v} - trial);
        dout.res <= (din.res >> 1) + bitv;
      end else begin
        dout.res <= din.res >> 1;
      end
    end
  end

endmodule

// File: rtl/gpg_color.sv
// Color back end: transparent-stop fixup, dither compare and channel mix in two
// stages, the second being the output register. Depends on gpg_pkg.
module gpg_color (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  gpg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  gpg_pkg::root_t din,
  output logic           out_valid,
  output logic [31:0]    pixel_color
);

  localparam int PRW = gpg_pkg::FRAC_BITS + 9;

  logic [gpg_pkg::FRAC_BITS:0]   f, finv;
  logic                          a0z, a1z, dlt;
  logic [31:0]                   c0a, c1a;
  logic [3:0]                    tsel, tval;
  logic [gpg_pkg::FRAC_BITS+5:0] dprod, thr;
  logic [PRW-1:0]                pa [4];
  logic [PRW-1:0]                pb [4];

  // Stage 1 registers.
  logic                          v1, dlt1;
  logic [31:0]                   c0a1, c1a1;
  logic [PRW-1:0]                pa1 [4];
  logic [PRW-1:0]                pb1 [4];
  gpg_pkg::side_t                side1;

  logic [PRW:0]                  msum [4];
  logic [31:0]                   mixc, res;

  // Stage 1: factor, color fixup, threshold compare and channel products.
  always_comb begin
    f     = cfg.mode[gpg_pkg::MODE_RADIAL] ? din.res[gpg_pkg::FRAC_BITS:0] : din.f;
    finv  = gpg_pkg::F_ONE - f;
    a0z   = cfg.c0[31:24] == 8'h00;
    a1z   = cfg.c1[31:24] == 8'h00;
    c0a   = (a0z && !a1z) ? {8'h00, cfg.c1[23:0]} : cfg.c0;
    c1a   = (!a0z && a1z) ? {8'h00, cfg.c0[23:0]} : cfg.c1;
    tsel  = {2'(din.side.pym), 2'(din.side.pxm)};
    tval  = cfg.dtab[{tsel, 2'b00} +: 4];
    dprod = f * (gpg_pkg::FRAC_BITS + 6)'({1'b0, cfg.dmax} + 5'd2);
    thr   = (gpg_pkg::FRAC_BITS + 6)'({{1'b0, tval} + 5'd1, {gpg_pkg::FRAC_BITS{1'b0}}});
    dlt   = dprod < thr;
    for (int i = 0; i < 4; i++) begin
      pa[i] = c0a[8*i +: 8] * finv;
      pb[i] = c1a[8*i +: 8] * f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      dlt1  <= dlt;
      c0a1  <= c0a;
      c1a1  <= c1a;
      pa1   <= pa;
      pb1   <= pb;
      side1 <= din.side;
    end
  end

  // Stage 2: channel sums, then pick the final color.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      msum[i] = (PRW + 1)'(pa1[i]) + (PRW + 1)'(pb1[i]);
      if (cfg.mode[gpg_pkg::MODE_RADIAL]) begin
        msum[i] = msum[i] + ((PRW + 1)'(1) << (gpg_pkg::FRAC_BITS - 1));
      end
      mixc[8*i +: 8] = msum[i][gpg_pkg::FRAC_BITS +: 8];
    end
    if (side1.fixed) begin
      case (side1.fsel)
        gpg_pkg::FIX_START_RAW: res = cfg.c0;
        gpg_pkg::FIX_END_RAW:   res = cfg.c1;
        default:                res = c1a1;
      endcase
    end else if (cfg.mode[gpg_pkg::MODE_DITHER]) begin
      res = dlt1 ? c0a1 : c1a1;
    end else begin
      res = mixc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      pixel_color <= res;
    end
  end

endmodule
